### hw/rtl/mpmm_pkg.sv
// shared types and codes for the multi-port message mailbox
package mpmm_pkg;

	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_DESTROY = 3'd1;
	localparam logic [2:0] MODE_SEND    = 3'd2;
	localparam logic [2:0] MODE_RECEIVE = 3'd3;
	localparam logic [2:0] MODE_REPLY   = 3'd4;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_ERR     = 2'd1;
	localparam logic [1:0] STS_BLOCKED = 2'd2;

	// classified request, as handed from the front end to the back end
	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  port_index;
		logic        port_ok;
		logic [15:0] task_id;
		logic        caller_known;
		logic        nonblocking;
		logic [63:0] message;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  port_created;
		logic [63:0] message_out;
		logic        wake_valid;
		logic [15:0] wake_task;
		logic        last;
	} rsp_t;

	function automatic rsp_t mk_rsp(logic [1:0] status, logic [3:0] created,
		logic [63:0] msg, logic wv, logic [15:0] wt, logic last);
		rsp_t r;
		r.status       = status;
		r.port_created = created;
		r.message_out  = msg;
		r.wake_valid   = wv;
		r.wake_task    = wt;
		r.last         = last;
		return r;
	endfunction

endpackage

### hw/rtl/mpmm_if.sv
// request and result channel interfaces of the mailbox
interface mpmm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [3:0]  port_index;
	logic [15:0] task_id;
	logic        caller_known;
	logic        nonblocking;
	logic [63:0] message_in;

	modport source (output valid, mode, port_index, task_id, caller_known, nonblocking,
		message_in, input ready);
	modport sink (input valid, mode, port_index, task_id, caller_known, nonblocking,
		message_in, output ready);
endinterface

interface mpmm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  port_created;
	logic [63:0] message_out;
	logic        wake_valid;
	logic [15:0] wake_task;
	logic        last;

	modport source (output valid, status, port_created, message_out, wake_valid,
		wake_task, last, input ready);
	modport sink (input valid, status, port_created, message_out, wake_valid,
		wake_task, last, output ready);
endinterface

### hw/rtl/multi_port_message_mailbox.sv
// top level of the multi-port message mailbox
// A request goes from acceptance to its result in steps: it leaves the command queue,
// is dispatched and is carried out, with one more step when a message or a waiting
// task is read from storage; a request that fails its port check ends at dispatch.
// Create and reply walk the port table one port per cycle. A destroy of a port with
// waiters reads each waiter from storage and then gives one result for it, senders
// first. The back end works on one request at a time; the front end keeps taking
// requests into a two-entry queue, and a full result register does not stop intake
// until that queue fills. Message rings and wait lists sit in memories with registered
// reads; no clearing pass is needed, since create resets a port's ring pointers and
// wait counts.
module multi_port_message_mailbox
	import mpmm_pkg::*;
#(
	parameter int NUM_PORTS    = 16,
	parameter int QUEUE_SLOTS  = 16,
	parameter int WAIT_DEPTH   = 8,
	parameter int MESSAGE_BITS = 64,
	parameter int TASK_BITS    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mpmm_req_if.sink   req,
	mpmm_rsp_if.source rsp
);
	// classified request between front and back
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// intake and command queue
	mpmm_front #(
		.NUM_PORTS(NUM_PORTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	// request execution and result register
	mpmm_back #(
		.NUM_PORTS   (NUM_PORTS),
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.WAIT_DEPTH  (WAIT_DEPTH),
		.MESSAGE_BITS(MESSAGE_BITS),
		.TASK_BITS   (TASK_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp      (rsp)
	);
endmodule

### hw/rtl/mpmm_front.sv
// front end: request intake, classification and a two-entry command queue
module mpmm_front
	import mpmm_pkg::*;
#(
	parameter int NUM_PORTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mpmm_req_if.sink    req,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	cmd_t       c;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = ent_q[rp_q];

	always_comb begin
		c.mode         = req.mode;
		c.port_index   = req.port_index;
		c.port_ok      = (32'(req.port_index) < 32'(NUM_PORTS));
		c.task_id      = req.task_id;
		c.caller_known = req.caller_known;
		c.nonblocking  = req.nonblocking;
		c.message      = req.message_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### hw/rtl/mpmm_back.sv
// back end: port table, message rings, wait lists and result register
module mpmm_back
	import mpmm_pkg::*;
#(
	parameter int NUM_PORTS    = 16,
	parameter int QUEUE_SLOTS  = 16,
	parameter int WAIT_DEPTH   = 8,
	parameter int MESSAGE_BITS = 64,
	parameter int TASK_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	mpmm_rsp_if.source  rsp
);
	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int QB = $clog2(QUEUE_SLOTS);
	localparam int SB = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CB = $clog2(WAIT_DEPTH + 1);
	localparam int TW = (TASK_BITS < 16) ? TASK_BITS : 16;
	localparam int MW = MESSAGE_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_EXEC = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;
	localparam logic [2:0] ST_DRD  = 3'd5;
	localparam logic [2:0] ST_DEM  = 3'd6;

	function automatic logic [SB-1:0] wslot(logic [SB-1:0] h, logic [CB-1:0] n);
		int s;
		s = int'(h) + int'(n);
		if (s >= WAIT_DEPTH) begin
			s = s - WAIT_DEPTH;
		end
		return SB'(s);
	endfunction

	function automatic logic [SB-1:0] wnext(logic [SB-1:0] h);
		return (h == SB'(WAIT_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [QB-1:0] qnext(logic [QB-1:0] h);
		return (h == QB'(QUEUE_SLOTS - 1)) ? '0 : h + 1'b1;
	endfunction

	// port table
	logic          used_q  [NUM_PORTS];
	logic [TW-1:0] owner_q [NUM_PORTS];
	logic [QB-1:0] head_q  [NUM_PORTS];
	logic [QB-1:0] tail_q  [NUM_PORTS];
	logic [CB-1:0] scnt_q  [NUM_PORTS];
	logic [CB-1:0] rcnt_q  [NUM_PORTS];
	logic [SB-1:0] shead_q [NUM_PORTS];
	logic [SB-1:0] rhead_q [NUM_PORTS];

	// storage
	logic [MW-1:0] msg_mem [NUM_PORTS << QB];
	logic [TW-1:0] sw_mem  [NUM_PORTS << SB];
	logic [TW-1:0] rw_mem  [NUM_PORTS << SB];
	logic [MW-1:0] msg_rd_q;
	logic [TW-1:0] sw_rd_q, rw_rd_q;

	logic [2:0]    st_q;
	cmd_t          cmd_q;
	logic [PW-1:0] cur_q;
	logic [CB-1:0] i_q;
	logic          phase_q;
	logic          ovalid_q;
	rsp_t          out_q;

	logic          can_emit, in_dstr;
	logic [TW-1:0] tsk;
	logic [MW-1:0] msg;
	logic          c_used;
	logic [QB-1:0] c_head, c_tail, c_next;
	logic          c_full, c_empty;
	logic [CB-1:0] c_scnt, c_rcnt, dcnt;
	logic [SB-1:0] c_shead, c_rhead;
	logic          blk_err, d_end, d_last;
	logic [PW+QB-1:0] m_raddr, m_waddr;
	logic [PW+SB-1:0] sw_raddr, rw_raddr, sw_waddr, rw_waddr;
	logic          m_we, sw_we, rw_we;

	assign can_emit  = !ovalid_q || rsp.ready;
	assign cmd_ready = (st_q == ST_IDLE);
	assign in_dstr   = (st_q == ST_DRD) || (st_q == ST_DEM);
	assign tsk       = TW'(cmd_q.task_id);
	assign msg       = MW'(cmd_q.message);

	assign c_used  = used_q[cur_q];
	assign c_head  = head_q[cur_q];
	assign c_tail  = tail_q[cur_q];
	assign c_next  = qnext(c_tail);
	assign c_full  = (c_next == c_head);
	assign c_empty = (c_head == c_tail);
	assign c_scnt  = scnt_q[cur_q];
	assign c_rcnt  = rcnt_q[cur_q];
	assign c_shead = shead_q[cur_q];
	assign c_rhead = rhead_q[cur_q];
	assign blk_err = cmd_q.nonblocking || !cmd_q.caller_known;
	assign dcnt    = phase_q ? c_rcnt : c_scnt;
	assign d_end   = (i_q + 1'b1 == dcnt);
	assign d_last  = d_end && (phase_q || (c_rcnt == '0));

	assign m_raddr  = {cur_q, c_head};
	assign m_waddr  = {cur_q, c_tail};
	assign sw_raddr = {cur_q, wslot(c_shead, (in_dstr && !phase_q) ? i_q : '0)};
	assign rw_raddr = {cur_q, wslot(c_rhead, (in_dstr && phase_q) ? i_q : '0)};
	assign sw_waddr = {cur_q, wslot(c_shead, c_scnt)};
	assign rw_waddr = {cur_q, wslot(c_rhead, c_rcnt)};

	// memory writes happen in the cycle the send or block is carried out
	always_comb begin
		m_we  = 1'b0;
		sw_we = 1'b0;
		rw_we = 1'b0;
		if (st_q == ST_EXEC) begin
			if (cmd_q.mode == MODE_SEND) begin
				if (!c_full) begin
					m_we = (c_rcnt != '0) || can_emit;
				end else begin
					sw_we = can_emit && !blk_err && (c_scnt < CB'(WAIT_DEPTH));
				end
			end else if (c_empty) begin
				rw_we = can_emit && !blk_err && (c_rcnt < CB'(WAIT_DEPTH));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			msg_mem[m_waddr] <= msg;
		end
		if (sw_we) begin
			sw_mem[sw_waddr] <= tsk;
		end
		if (rw_we) begin
			rw_mem[rw_waddr] <= tsk;
		end
		msg_rd_q <= msg_mem[m_raddr];
		sw_rd_q  <= sw_mem[sw_raddr];
		rw_rd_q  <= rw_mem[rw_raddr];
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = out_q.status;
	assign rsp.port_created = out_q.port_created;
	assign rsp.message_out  = out_q.message_out;
	assign rsp.wake_valid   = out_q.wake_valid;
	assign rsp.wake_task    = out_q.wake_task;
	assign rsp.last         = out_q.last;

	always_ff @(posedge clk) begin
		if (can_emit) begin
			case (st_q)
				ST_DISP: begin
					// a destroy of a live port with no waiters ends here with ok
					if (cmd_q.mode == MODE_DESTROY && cmd_q.port_ok && c_used) begin
						out_q <= mk_rsp(STS_OK, 4'd0, 64'd0, 1'b0, 16'd0, 1'b1);
					end else begin
						out_q <= mk_rsp(STS_ERR, 4'd0, 64'd0, 1'b0, 16'd0, 1'b1);
					end
				end
				ST_SCAN: begin
					if (cmd_q.mode == MODE_CREATE && !c_used) begin
						out_q <= mk_rsp(STS_OK, 4'(cur_q), 64'd0, 1'b0, 16'd0, 1'b1);
					end else begin
						out_q <= mk_rsp(STS_ERR, 4'd0, 64'd0, 1'b0, 16'd0, 1'b1);
					end
				end
				ST_EXEC: begin
					if (cmd_q.mode == MODE_SEND && !c_full) begin
						out_q <= mk_rsp(STS_OK, 4'd0, 64'd0, 1'b0, 16'd0, 1'b1);
					end else begin
						out_q <= mk_rsp(blk_err ? STS_ERR : STS_BLOCKED, 4'd0, 64'd0,
							1'b0, 16'd0, 1'b1);
					end
				end
				ST_RESP: begin
					if (cmd_q.mode == MODE_SEND) begin
						out_q <= mk_rsp(STS_OK, 4'd0, 64'd0, 1'b1, 16'(rw_rd_q), 1'b1);
					end else if (c_scnt != '0) begin
						out_q <= mk_rsp(STS_OK, 4'd0, 64'(msg_rd_q), 1'b1, 16'(sw_rd_q), 1'b1);
					end else begin
						out_q <= mk_rsp(STS_OK, 4'd0, 64'(msg_rd_q), 1'b0, 16'd0, 1'b1);
					end
				end
				ST_DEM: out_q <= mk_rsp(STS_OK, 4'd0, 64'd0, 1'b1,
					16'(phase_q ? rw_rd_q : sw_rd_q), d_last);
				default: out_q <= mk_rsp(STS_OK, 4'd0, 64'd0, 1'b0, 16'd0, 1'b1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cmd_q    <= '0;
			cur_q    <= '0;
			i_q      <= '0;
			phase_q  <= 1'b0;
			ovalid_q <= 1'b0;
			for (int p = 0; p < NUM_PORTS; p++) begin
				used_q[p]  <= 1'b0;
				owner_q[p] <= '0;
				head_q[p]  <= '0;
				tail_q[p]  <= '0;
				scnt_q[p]  <= '0;
				rcnt_q[p]  <= '0;
				shead_q[p] <= '0;
				rhead_q[p] <= '0;
			end
		end else begin
			if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						cur_q <= PW'(cmd.port_index);
						st_q  <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (cmd_q.mode == MODE_CREATE || cmd_q.mode == MODE_REPLY) begin
						cur_q <= '0;
						st_q  <= ST_SCAN;
					end else if (cmd_q.mode > MODE_REPLY || !cmd_q.port_ok || !c_used) begin
						if (can_emit) begin
							ovalid_q <= 1'b1;
							st_q     <= ST_IDLE;
						end
					end else if (cmd_q.mode == MODE_DESTROY) begin
						i_q     <= '0;
						phase_q <= (c_scnt == '0);
						if (c_scnt != '0 || c_rcnt != '0) begin
							st_q <= ST_DRD;
						end else if (can_emit) begin
							ovalid_q       <= 1'b1;
							used_q[cur_q]  <= 1'b0;
							owner_q[cur_q] <= '0;
							head_q[cur_q]  <= '0;
							tail_q[cur_q]  <= '0;
							st_q           <= ST_IDLE;
						end
					end else begin
						st_q <= ST_EXEC;
					end
				end
				ST_SCAN: begin
					if (cmd_q.mode == MODE_CREATE && !c_used) begin
						if (can_emit) begin
							ovalid_q       <= 1'b1;
							used_q[cur_q]  <= 1'b1;
							owner_q[cur_q] <= tsk;
							head_q[cur_q]  <= '0;
							tail_q[cur_q]  <= '0;
							scnt_q[cur_q]  <= '0;
							rcnt_q[cur_q]  <= '0;
							shead_q[cur_q] <= '0;
							rhead_q[cur_q] <= '0;
							st_q           <= ST_IDLE;
						end
					end else if (cmd_q.mode == MODE_REPLY && c_used && owner_q[cur_q] == tsk) begin
						cmd_q.mode        <= MODE_SEND;
						cmd_q.nonblocking <= 1'b1;
						st_q              <= ST_EXEC;
					end else if (32'(cur_q) == 32'(NUM_PORTS - 1)) begin
						if (can_emit) begin
							ovalid_q <= 1'b1;
							st_q     <= ST_IDLE;
						end
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				ST_EXEC: begin
					if (cmd_q.mode == MODE_SEND && !c_full && c_rcnt != '0) begin
						tail_q[cur_q] <= c_next;
						st_q          <= ST_RESP;
					end else if (cmd_q.mode == MODE_RECEIVE && !c_empty) begin
						st_q <= ST_RESP;
					end else if (can_emit) begin
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
						if (sw_we) begin
							scnt_q[cur_q] <= c_scnt + 1'b1;
						end
						if (rw_we) begin
							rcnt_q[cur_q] <= c_rcnt + 1'b1;
						end
						if (m_we) begin
							tail_q[cur_q] <= c_next;
						end
					end
				end
				ST_RESP: begin
					if (can_emit) begin
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
						if (cmd_q.mode == MODE_SEND) begin
							rcnt_q[cur_q]  <= c_rcnt - 1'b1;
							rhead_q[cur_q] <= wnext(c_rhead);
						end else begin
							head_q[cur_q] <= qnext(c_head);
							if (c_scnt != '0) begin
								scnt_q[cur_q]  <= c_scnt - 1'b1;
								shead_q[cur_q] <= wnext(c_shead);
							end
						end
					end
				end
				ST_DRD: st_q <= ST_DEM;
				ST_DEM: begin
					if (can_emit) begin
						ovalid_q <= 1'b1;
						if (d_last) begin
							used_q[cur_q]  <= 1'b0;
							owner_q[cur_q] <= '0;
							head_q[cur_q]  <= '0;
							tail_q[cur_q]  <= '0;
							scnt_q[cur_q]  <= '0;
							rcnt_q[cur_q]  <= '0;
							shead_q[cur_q] <= '0;
							rhead_q[cur_q] <= '0;
							st_q           <= ST_IDLE;
						end else if (d_end) begin
							phase_q <= 1'b1;
							i_q     <= '0;
							st_q    <= ST_DRD;
						end else begin
							i_q  <= i_q + 1'b1;
							st_q <= ST_DRD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/mpmm_chk.sv
// port-level checker for the mailbox result channel, with its bind
module mpmm_chk
	import mpmm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  status,
	input logic [3:0]  port_created,
	input logic        wake_valid,
	input logic [15:0] wake_task,
	input logic        last
);
	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid) else $error("result dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> status != 2'd3) else $error("status code out of range");

	// error and blocked requests give a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != STS_OK |-> last) else $error("failed request not last");

	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		valid && port_created != 4'd0 |-> status == STS_OK && !wake_valid)
		else $error("port index on a non-create result");

	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !wake_valid |-> wake_task == 16'd0) else $error("stray wake task");
endmodule

bind multi_port_message_mailbox mpmm_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (rsp.valid),
	.ready       (rsp.ready),
	.status      (rsp.status),
	.port_created(rsp.port_created),
	.wake_valid  (rsp.wake_valid),
	.wake_task   (rsp.wake_task),
	.last        (rsp.last)
);
